// File: sv/vfcm_pkg.sv
// Shared types, sizes and constant tables for the voxel face-culling mesher.
// Used by the controller, the datapath and the top level; depends on nothing.

package vfcm_pkg;

    // Cube geometry and stored type width.
    localparam int SIDE      = 16;
    localparam int TYPE_BITS = 8;
    localparam int CELLS     = SIDE * SIDE * SIDE;
    localparam int ADDR_W    = $clog2(CELLS);

    // Port field widths.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 5;
    localparam int NTYPE_W = 8;
    localparam int VPOS_W  = 6;
    localparam int FACE_W  = 3;

    localparam int NUM_FACES   = 6;
    localparam int VERTS_FACE  = 6;

    // Face codes, in emission order.
    localparam logic [FACE_W-1:0] FACE_NX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd5;

    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_EXAMINE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;     // latch the input beat
        logic                clear;       // write air at clear_addr
        logic [ADDR_W-1:0]   clear_addr;
        logic                write;       // store new type at the cell
        logic                probe;       // issue a store read
        logic                probe_self;  // read the cell itself
        logic [FACE_W-1:0]   probe_face;  // otherwise the neighbor across this face
        logic                load_read;   // load a read-data result
        logic                emit_start;  // point at the first visible face
        logic                emit_step;   // load one vertex and advance
    } vfcm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic in_cube;
        logic out_free;
        logic none_visible;
        logic emit_final;
    } vfcm_stat_t;

    // Linear store address of an in-cube cell.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [VPOS_W-1:0] x,
        input logic [VPOS_W-1:0] y,
        input logic [VPOS_W-1:0] z
    );
        logic [ADDR_W-1:0] side_a;
        side_a = ADDR_W'(SIDE);
        return (ADDR_W'(x) * side_a + ADDR_W'(y)) * side_a + ADDR_W'(z);
    endfunction

    // Quad corner used by each vertex of a face (two triangles).
    function automatic logic [1:0] emit_corner(input logic [2:0] vert);
        logic [1:0] c;
        case (vert)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd0;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // Corner offsets packed as {dx, dy, dz}.
    function automatic logic [2:0] corner_offset(
        input logic [FACE_W-1:0] face,
        input logic [1:0]        corner
    );
        logic [2:0] o;
        o = 3'b000;
        case (face)
            FACE_NX: case (corner)
                2'd0: o = 3'b000; 2'd1: o = 3'b001; 2'd2: o = 3'b011; default: o = 3'b010;
            endcase
            FACE_PX: case (corner)
                2'd0: o = 3'b101; 2'd1: o = 3'b100; 2'd2: o = 3'b110; default: o = 3'b111;
            endcase
            FACE_NY: case (corner)
                2'd0: o = 3'b000; 2'd1: o = 3'b100; 2'd2: o = 3'b101; default: o = 3'b001;
            endcase
            FACE_PY: case (corner)
                2'd0: o = 3'b011; 2'd1: o = 3'b111; 2'd2: o = 3'b110; default: o = 3'b010;
            endcase
            FACE_NZ: case (corner)
                2'd0: o = 3'b100; 2'd1: o = 3'b000; 2'd2: o = 3'b010; default: o = 3'b110;
            endcase
            FACE_PZ: case (corner)
                2'd0: o = 3'b001; 2'd1: o = 3'b101; 2'd2: o = 3'b111; default: o = 3'b011;
            endcase
            default: o = 3'b000;
        endcase
        return o;
    endfunction

endpackage

// File: sv/voxel_face_cull_mesher_unit.sv
// Voxel face-culling mesher. Write: stored at dispatch. Read: one store read, then the
// result beat. Examine: seven store reads (cell plus six neighbors, one read port, one
// read a cycle), then one vertex beat a cycle, up to 36, as the sink takes them.
// One item at a time; the next beat is taken once the controller is back in idle.
// After reset the store is swept to air, one cell a cycle (SIDE^3 = 4096 cells),
// and no beat is taken until the sweep ends. Depends on vfcm_pkg, vfcm_ctrl, vfcm_dp.

module voxel_face_cull_mesher_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [vfcm_pkg::CMD_W-1:0]       cmd,
    input  logic [vfcm_pkg::COORD_W-1:0]     cx,
    input  logic [vfcm_pkg::COORD_W-1:0]     cy,
    input  logic [vfcm_pkg::COORD_W-1:0]     cz,
    input  logic [vfcm_pkg::NTYPE_W-1:0]     new_type,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [vfcm_pkg::VPOS_W-1:0]      vx,
    output logic [vfcm_pkg::VPOS_W-1:0]      vy,
    output logic [vfcm_pkg::VPOS_W-1:0]      vz,
    output logic [vfcm_pkg::FACE_W-1:0]      face_id,
    output logic [vfcm_pkg::NTYPE_W-1:0]     type_out,
    output logic                             last
);
    import vfcm_pkg::*;

    vfcm_cmd_t  ctl;
    vfcm_stat_t stat;

    vfcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    vfcm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cmd       (cmd),
        .cx        (cx),
        .cy        (cy),
        .cz        (cz),
        .new_type  (new_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .vx        (vx),
        .vy        (vy),
        .vz        (vz),
        .face_id   (face_id),
        .type_out  (type_out),
        .last      (last)
    );

endmodule

// File: sv/vfcm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.

module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/vfcm_ctrl.sv
// Controller of the mesher: clearing sweep, command dispatch, probe sequence
// and vertex emission. Depends on vfcm_pkg.

module vfcm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  vfcm_pkg::vfcm_stat_t   stat,
    output vfcm_pkg::vfcm_cmd_t    ctl
);
    import vfcm_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_RD_WAIT,
        ST_RD_OUT,
        ST_PROBE,
        ST_SETTLE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FACE_W-1:0]   face_cnt_reg, face_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        face_cnt_next = face_cnt_reg;
        ctl           = '0;
        ctl.clear_addr = clr_cnt_reg;
        ctl.probe_face = face_cnt_reg;
        in_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (stat.op)
                    OP_WRITE:
                    begin
                        ctl.write  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_READ:
                    begin
                        ctl.probe      = 1'b1;
                        ctl.probe_self = 1'b1;
                        state_next     = ST_RD_WAIT;
                    end
                    OP_EXAMINE:
                    begin
                        if (stat.in_cube)
                        begin
                            ctl.probe      = 1'b1;
                            ctl.probe_self = 1'b1;
                            face_cnt_next  = FACE_NX;
                            state_next     = ST_PROBE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                ctl.probe     = 1'b1;
                face_cnt_next = face_cnt_reg + 1'b1;
                if (face_cnt_reg == FACE_PZ)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.none_visible)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.emit_start = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_step = 1'b1;
                    if (stat.emit_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            face_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            face_cnt_reg <= face_cnt_next;
        end
    end

endmodule

// File: sv/vfcm_dp.sv
// Datapath of the mesher: input latch, block store, neighbor probing,
// visibility mask, vertex generation and the output register.
// Depends on vfcm_pkg and vfcm_ram.

module vfcm_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vfcm_pkg::vfcm_cmd_t              ctl,
    output vfcm_pkg::vfcm_stat_t             stat,
    input  logic [vfcm_pkg::CMD_W-1:0]       cmd,
    input  logic [vfcm_pkg::COORD_W-1:0]     cx,
    input  logic [vfcm_pkg::COORD_W-1:0]     cy,
    input  logic [vfcm_pkg::COORD_W-1:0]     cz,
    input  logic [vfcm_pkg::NTYPE_W-1:0]     new_type,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [vfcm_pkg::VPOS_W-1:0]      vx,
    output logic [vfcm_pkg::VPOS_W-1:0]      vy,
    output logic [vfcm_pkg::VPOS_W-1:0]      vz,
    output logic [vfcm_pkg::FACE_W-1:0]      face_id,
    output logic [vfcm_pkg::NTYPE_W-1:0]     type_out,
    output logic                             last
);
    import vfcm_pkg::*;

    // Latched input beat.
    op_t                     op_reg;
    logic [COORD_W-1:0]      x_reg, y_reg, z_reg;
    logic [TYPE_BITS-1:0]    type_reg;

    // Probe results.
    logic                    probe_v_reg;
    logic                    probe_self_reg;
    logic [FACE_W-1:0]       probe_face_reg;
    logic                    probe_oob_reg;
    logic [TYPE_BITS-1:0]    self_type_reg;
    logic [NUM_FACES-1:0]    vis_mask_reg;

    // Emission position.
    logic [FACE_W-1:0]       face_reg;
    logic [2:0]              vert_reg;

    // Output register.
    logic                    out_valid_reg;
    logic                    kind_reg;
    logic [VPOS_W-1:0]       vx_reg, vy_reg, vz_reg;
    logic [FACE_W-1:0]       face_id_reg;
    logic [NTYPE_W-1:0]      type_out_reg;
    logic                    last_reg;

    logic [VPOS_W-1:0]       sx, sy, sz;
    logic [VPOS_W-1:0]       px, py, pz;
    logic                    self_in_cube;
    logic                    probe_oob;
    logic [ADDR_W-1:0]       self_addr;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [TYPE_BITS-1:0]    ram_wdata;
    logic [TYPE_BITS-1:0]    ram_rdata;
    logic [FACE_W-1:0]       first_face;
    logic [FACE_W-1:0]       next_face;
    logic                    has_more;
    logic [2:0]              offs;
    logic                    out_free;

    assign sx = {1'b0, x_reg};
    assign sy = {1'b0, y_reg};
    assign sz = {1'b0, z_reg};

    assign self_in_cube = (sx < VPOS_W'(SIDE)) && (sy < VPOS_W'(SIDE)) && (sz < VPOS_W'(SIDE));
    assign self_addr    = cell_addr(sx, sy, sz);

    // Neighbor coordinates; a step below zero wraps high and reads as out of cube.
    always_comb
    begin
        px = sx;
        py = sy;
        pz = sz;
        if (!ctl.probe_self)
        begin
            case (ctl.probe_face)
                FACE_NX: px = sx - 1'b1;
                FACE_PX: px = sx + 1'b1;
                FACE_NY: py = sy - 1'b1;
                FACE_PY: py = sy + 1'b1;
                FACE_NZ: pz = sz - 1'b1;
                FACE_PZ: pz = sz + 1'b1;
                default: px = sx;
            endcase
        end
    end

    assign probe_oob = (px >= VPOS_W'(SIDE)) || (py >= VPOS_W'(SIDE)) || (pz >= VPOS_W'(SIDE));

    assign ram_we    = ctl.clear || (ctl.write && self_in_cube);
    assign ram_waddr = ctl.clear ? ctl.clear_addr : self_addr;
    assign ram_wdata = ctl.clear ? '0 : type_reg;

    vfcm_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_addr(px, py, pz)),
        .rdata (ram_rdata)
    );

    // Lowest visible face, and the next visible face above the current one.
    always_comb
    begin
        first_face = FACE_NX;
        next_face  = FACE_NX;
        has_more   = 1'b0;
        for (int i = NUM_FACES - 1; i >= 0; i--)
        begin
            if (vis_mask_reg[i])
            begin
                first_face = FACE_W'(i);
            end
            if (vis_mask_reg[i] && (FACE_W'(i) > face_reg))
            begin
                next_face = FACE_W'(i);
                has_more  = 1'b1;
            end
        end
    end

    assign offs     = corner_offset(face_reg, emit_corner(vert_reg));
    assign out_free = !out_valid_reg || out_ready;

    assign stat.op           = op_reg;
    assign stat.in_cube      = self_in_cube;
    assign stat.out_free     = out_free;
    assign stat.none_visible = (self_type_reg == '0) || (vis_mask_reg == '0);
    assign stat.emit_final   = (vert_reg == 3'(VERTS_FACE - 1)) && !has_more;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= op_t'(cmd);
            x_reg    <= cx;
            y_reg    <= cy;
            z_reg    <= cz;
            type_reg <= new_type[TYPE_BITS-1:0];
        end

        if (ctl.probe)
        begin
            probe_self_reg <= ctl.probe_self;
            probe_face_reg <= ctl.probe_face;
            probe_oob_reg  <= probe_oob;
        end

        // Store data arrives in the cycle after the probe address.
        if (probe_v_reg)
        begin
            if (probe_self_reg)
            begin
                self_type_reg <= probe_oob_reg ? '0 : ram_rdata;
            end
            else
            begin
                vis_mask_reg[probe_face_reg] <= probe_oob_reg || (ram_rdata == '0);
            end
        end

        if (ctl.emit_start)
        begin
            face_reg <= first_face;
            vert_reg <= '0;
        end
        else if (ctl.emit_step)
        begin
            if (vert_reg == 3'(VERTS_FACE - 1))
            begin
                face_reg <= next_face;
                vert_reg <= '0;
            end
            else
            begin
                vert_reg <= vert_reg + 1'b1;
            end
        end

        if (ctl.load_read)
        begin
            kind_reg     <= KIND_READ;
            vx_reg       <= '0;
            vy_reg       <= '0;
            vz_reg       <= '0;
            face_id_reg  <= '0;
            type_out_reg <= NTYPE_W'(self_type_reg);
            last_reg     <= 1'b1;
        end
        else if (ctl.emit_step)
        begin
            kind_reg     <= KIND_VERTEX;
            vx_reg       <= sx + VPOS_W'(offs[2]);
            vy_reg       <= sy + VPOS_W'(offs[1]);
            vz_reg       <= sz + VPOS_W'(offs[0]);
            face_id_reg  <= face_reg;
            type_out_reg <= NTYPE_W'(self_type_reg);
            last_reg     <= stat.emit_final;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_v_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            probe_v_reg <= ctl.probe;
            if (ctl.load_read || ctl.emit_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign vx        = vx_reg;
    assign vy        = vy_reg;
    assign vz        = vz_reg;
    assign face_id   = face_id_reg;
    assign type_out  = type_out_reg;
    assign last      = last_reg;

endmodule
